// ===== rtl/dnat_pkg.sv =====
// ----------------------------------------------------------------------------
// dnat_pkg
// Types and constants shared by the destination NAT header rewrite block.
// ----------------------------------------------------------------------------
package dnat_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ADDRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_ENABLE = 2'd2;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 328;

    typedef struct packed {
        logic        watchdog_expired;
        logic        eth_header_present;
        logic [15:0] ether_type;
        logic        ip_header_present;
        logic [31:0] dest_address;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_checksum;
        logic        l4_header_present;
        logic [15:0] l4_checksum;
    } in_item_t;

    typedef struct packed {
        logic        rewritten;
        logic        l4_rewritten;
        logic [31:0] dest_address_out;
        logic [15:0] ip_checksum_out;
        logic [15:0] l4_checksum_out;
    } rewrite_t;

    typedef struct packed {
        logic forwarded;
        logic other_type;
        logic unmatched;
    } count_inc_t;

    typedef struct packed {
        logic [63:0] total;
        logic [63:0] forwarded;
        logic [63:0] other_type;
        logic [63:0] unmatched;
    } counts_t;

endpackage

// ===== rtl/dnat_csum.sv =====
// ----------------------------------------------------------------------------
// dnat_csum
// Incremental ones' complement checksum update for a 32-bit field change.
// ----------------------------------------------------------------------------
module dnat_csum
(
    input  logic [15:0] check,
    input  logic [31:0] old_val,
    input  logic [31:0] new_val,
    output logic [15:0] check_out
);

    logic [18:0] sum;
    logic [16:0] fold1;
    logic [16:0] fold2;

    // HC' = ~(~HC + ~m + m')
    always_comb
    begin
        sum = {3'd0, ~check} + {3'd0, ~old_val[31:16]} + {3'd0, ~old_val[15:0]}
            + {3'd0, new_val[31:16]} + {3'd0, new_val[15:0]};
        fold1 = {1'b0, sum[15:0]} + {14'd0, sum[18:16]};
        fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        check_out = ~fold2[15:0];
    end

endmodule

// ===== rtl/dnat_core.sv =====
// ----------------------------------------------------------------------------
// dnat_core
// Packet classification, address rewrite and checksum updates for one item.
// ----------------------------------------------------------------------------
module dnat_core
(
    input  dnat_pkg::in_item_t   item,
    input  logic [31:0]          match_address,
    input  logic [31:0]          target_address,
    input  logic                 forward_enable,
    output dnat_pkg::rewrite_t   res,
    output dnat_pkg::count_inc_t inc
);
    import dnat_pkg::*;

    logic [15:0] ip_ck_new;
    logic [15:0] l4_ck_new;
    logic        active;
    logic        is_ipv4;
    logic        hit;
    logic        l4_ok;

    dnat_csum u_ip_csum
    (
        .check     (item.ip_checksum),
        .old_val   (item.dest_address),
        .new_val   (target_address),
        .check_out (ip_ck_new)
    );

    dnat_csum u_l4_csum
    (
        .check     (item.l4_checksum),
        .old_val   (item.dest_address),
        .new_val   (target_address),
        .check_out (l4_ck_new)
    );

    always_comb
    begin
        active  = !item.watchdog_expired && forward_enable && item.eth_header_present;
        is_ipv4 = (item.ether_type == ETHERTYPE_IPV4);
        hit     = active && is_ipv4 && item.ip_header_present
                  && (item.dest_address == match_address);
        l4_ok   = ((item.ip_protocol == PROTO_TCP) || (item.ip_protocol == PROTO_UDP))
                  && item.l4_header_present;

        inc.forwarded  = hit;
        inc.other_type = active && !is_ipv4;
        inc.unmatched  = active && is_ipv4 && item.ip_header_present
                         && (item.dest_address != match_address);

        res.rewritten        = hit;
        res.l4_rewritten     = hit && l4_ok;
        res.dest_address_out = hit ? target_address : item.dest_address;
        res.ip_checksum_out  = hit ? ip_ck_new : item.ip_checksum;
        res.l4_checksum_out  = (hit && l4_ok) ? l4_ck_new : item.l4_checksum;
    end

endmodule

// ===== rtl/dnat_counters.sv =====
// ----------------------------------------------------------------------------
// dnat_counters
// Four wrapping 64-bit packet counters, stepped as each item completes.
// ----------------------------------------------------------------------------
module dnat_counters
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dnat_pkg::count_inc_t inc,
    output dnat_pkg::counts_t    counts
);
    import dnat_pkg::*;

    counts_t counts_reg;
    counts_t counts_next;

    always_comb
    begin
        counts_next            = counts_reg;
        counts_next.total      = counts_reg.total + 64'd1;
        counts_next.forwarded  = counts_reg.forwarded + {63'd0, inc.forwarded};
        counts_next.other_type = counts_reg.other_type + {63'd0, inc.other_type};
        counts_next.unmatched  = counts_reg.unmatched + {63'd0, inc.unmatched};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
        end
        else if (step)
        begin
            counts_reg <= counts_next;
        end
    end

    assign counts = counts_reg;

endmodule

// ===== rtl/dnat_header_rewrite.sv =====
// ----------------------------------------------------------------------------
// dnat_header_rewrite
// Destination NAT of parsed IPv4 headers with incremental checksum update.
// ----------------------------------------------------------------------------
// One item per packet, one item per clock sustained while m_tready is high. An
// accepted item sits in the input register, passes the match and checksum
// logic and lands in the result register once that register is free or its
// result is taken. The counter bank steps together with the result register,
// and the reported counts are the values after that packet. While a result
// waits on m_tready the input register takes at most one more item, then
// s_tready drops until the result is taken.
module dnat_header_rewrite
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [dnat_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dnat_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // watchdog_expired[0], eth_header_present[1], ether_type[17:2],
    // ip_header_present[18], dest_address[50:19], ip_protocol[58:51],
    // ip_checksum[74:59], l4_header_present[75], l4_checksum[91:76], zero pad
    input  logic [dnat_pkg::IN_DATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // rewritten[0], l4_rewritten[1], dest_address_out[33:2],
    // ip_checksum_out[49:34], l4_checksum_out[65:50], total_count[129:66],
    // forwarded_count[193:130], non-IPv4 count[257:194],
    // unmatched count[321:258], zero pad
    output logic [dnat_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import dnat_pkg::*;

    logic [31:0] match_address_reg;
    logic [31:0] target_address_reg;
    logic        forward_enable_reg;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    in_item_t    in_item_next;
    logic        out_valid_reg;
    rewrite_t    out_res_reg;
    rewrite_t    res;
    count_inc_t  inc;
    counts_t     counts;
    logic        adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_address_reg  <= '0;
            target_address_reg <= '0;
            forward_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MATCH_ADDRESS:  match_address_reg  <= cfg_wr_data;
                REG_TARGET_ADDRESS: target_address_reg <= cfg_wr_data;
                REG_FORWARD_ENABLE: forward_enable_reg <= cfg_wr_data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        in_item_next.watchdog_expired   = s_tdata[0];
        in_item_next.eth_header_present = s_tdata[1];
        in_item_next.ether_type         = s_tdata[17:2];
        in_item_next.ip_header_present  = s_tdata[18];
        in_item_next.dest_address       = s_tdata[50:19];
        in_item_next.ip_protocol        = s_tdata[58:51];
        in_item_next.ip_checksum        = s_tdata[74:59];
        in_item_next.l4_header_present  = s_tdata[75];
        in_item_next.l4_checksum        = s_tdata[91:76];
    end

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_next;
        end
    end

    dnat_core u_core
    (
        .item           (in_item_reg),
        .match_address  (match_address_reg),
        .target_address (target_address_reg),
        .forward_enable (forward_enable_reg),
        .res            (res),
        .inc            (inc)
    );

    dnat_counters u_counters
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (adv),
        .inc    (inc),
        .counts (counts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       counts.unmatched,
                       counts.other_type,
                       counts.forwarded,
                       counts.total,
                       out_res_reg.l4_checksum_out,
                       out_res_reg.ip_checksum_out,
                       out_res_reg.dest_address_out,
                       out_res_reg.l4_rewritten,
                       out_res_reg.rewritten};

    // the total counter steps by exactly one packet per completed item
    assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> counts.total == $past(counts.total) + 64'd1)
        else $error("total count did not follow completed item");

    // L4 update only ever accompanies an address rewrite
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.rewritten || !out_res_reg.l4_rewritten))
        else $error("l4 rewrite without address rewrite");

    // a held item stays in the input register while the result stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("input item lost during output stall");

endmodule
